>>> design/epc_pkg.sv
`default_nettype none

package epc_pkg;

    // Field widths.
    localparam int COORD_W   = 20;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int ACC_W     = PROD_W + 1;
    localparam int DEPTH_W   = 16;
    localparam int LAM_W     = 17;
    localparam int FRAC_W    = 16;
    localparam int DETMIN_W  = 41;
    localparam int CFG_W     = 41;
    localparam int CFG_IDX_W = 2;
    localparam int REQ_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int SEL_W     = 3;

    localparam int DEFAULT_MAX_POINTS = 64;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TEST   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FEW   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DEPTH = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DET_MIN     = 2'd2;

    localparam logic [LAM_W-1:0]    LAMBDA_LOW_RST  = 17'd328;
    localparam logic [LAM_W-1:0]    LAMBDA_HIGH_RST = 17'd65208;
    localparam logic [DETMIN_W-1:0] DET_MIN_RST     = 41'd1;

    localparam logic [LAM_W-1:0] Q16_ONE = 17'h10000;

    localparam logic signed [DEPTH_W-1:0] DEPTH_POS = 16'sd16384;
    localparam logic signed [DEPTH_W-1:0] DEPTH_NEG = -16'sd16384;

    // Products of one segment test, in issue order.
    localparam logic [SEL_W-1:0] MUL_AD = 3'd0;
    localparam logic [SEL_W-1:0] MUL_BC = 3'd1;
    localparam logic [SEL_W-1:0] MUL_DE = 3'd2;
    localparam logic [SEL_W-1:0] MUL_BF = 3'd3;
    localparam logic [SEL_W-1:0] MUL_AF = 3'd4;
    localparam logic [SEL_W-1:0] MUL_CE = 3'd5;
    localparam logic [SEL_W-1:0] MUL_LAST = 3'd6;

    typedef struct packed {
        logic                append;
        logic                clear;
        logic                latch_edge;
        logic                seg_first;
        logic                seg_next;
        logic                rd_q;
        logic                load;
        logic [SEL_W-1:0]    mul_sel;
        logic                acc_en;
        logic [SEL_W-1:0]    acc_sel;
        logic                norm;
        logic                div_start;
        logic                emit;
        logic [STATUS_W-1:0] res_status;
        logic                res_hit;
    } epc_cmd_t;

    typedef struct packed {
        logic is_append;
        logic is_clear;
        logic is_test;
        logic full;
        logic few;
        logic depth_bad;
        logic seg_ok;
        logic last_seg;
        logic div_done;
        logic lam_ok;
    } epc_stat_t;

    // Signed difference with one guard bit.
    function automatic logic signed [DIFF_W-1:0] sub_ext(
        input logic signed [COORD_W-1:0] x,
        input logic signed [COORD_W-1:0] y
    );
        logic signed [DIFF_W-1:0] xe;
        logic signed [DIFF_W-1:0] ye;
        xe = DIFF_W'(x);
        ye = DIFF_W'(y);
        return xe - ye;
    endfunction

endpackage

`default_nettype wire

>>> design/epc_div.sv
`default_nettype none

module epc_div
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [epc_pkg::ACC_W-2:0]       num,
    input  wire logic [epc_pkg::ACC_W-2:0]       den,
    output logic                                 done,
    output logic [epc_pkg::LAM_W-1:0]            quot
);

    localparam int NUM_W = epc_pkg::ACC_W - 1;
    localparam int REM_W = NUM_W + epc_pkg::LAM_W;
    localparam int CNT_W = $clog2(epc_pkg::LAM_W + 1);

    logic [REM_W-1:0]           rem_reg, rem_next;
    logic [REM_W-1:0]           dsh_reg, dsh_next;
    logic [epc_pkg::LAM_W-1:0]  q_reg, q_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic                       ge;

    // One quotient bit per cycle against a divisor shifted down each step.
    always_comb
    begin
        ge        = rem_reg >= dsh_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = REM_W'({num, {epc_pkg::FRAC_W{1'b0}}}) + REM_W'(den >> 1);
            dsh_next  = REM_W'({den, {epc_pkg::FRAC_W{1'b0}}});
            q_next    = '0;
            cnt_next  = CNT_W'(epc_pkg::LAM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? rem_reg - dsh_reg : rem_reg;
            dsh_next = dsh_reg >> 1;
            q_next   = {q_reg[epc_pkg::LAM_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

`default_nettype wire

>>> design/epc_datapath.sv
`default_nettype none

module epc_datapath
#(
    parameter int MAX_POINTS = epc_pkg::DEFAULT_MAX_POINTS,
    parameter int IDX_W      = $clog2(MAX_POINTS),
    parameter int CNT_W      = $clog2(MAX_POINTS + 1)
)
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire epc_pkg::epc_cmd_t                      cmd,
    output epc_pkg::epc_stat_t                          stat,
    input  wire logic                                   cfg_we,
    input  wire logic [epc_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [epc_pkg::CFG_W-1:0]              cfg_data,
    input  wire logic [epc_pkg::REQ_W-1:0]              req_type,
    input  wire logic signed [epc_pkg::COORD_W-1:0]     ax,
    input  wire logic signed [epc_pkg::COORD_W-1:0]     ay,
    input  wire logic signed [epc_pkg::COORD_W-1:0]     bx,
    input  wire logic signed [epc_pkg::COORD_W-1:0]     by,
    input  wire logic signed [epc_pkg::DEPTH_W-1:0]     az,
    input  wire logic signed [epc_pkg::DEPTH_W-1:0]     bz,
    input  wire logic                                   swapped,
    output logic                                        done,
    output logic [epc_pkg::STATUS_W-1:0]                status,
    output logic                                        hit,
    output logic [IDX_W-1:0]                            segment_index,
    output logic [epc_pkg::LAM_W-1:0]                   split_t,
    output logic [CNT_W-1:0]                            point_total
);

    localparam int ACC_W  = epc_pkg::ACC_W;
    localparam int DIFF_W = epc_pkg::DIFF_W;
    localparam int PROD_W = epc_pkg::PROD_W;

    // Configuration registers.
    logic [epc_pkg::LAM_W-1:0]    lambda_low_reg;
    logic [epc_pkg::LAM_W-1:0]    lambda_high_reg;
    logic [epc_pkg::DETMIN_W-1:0] det_min_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lambda_low_reg  <= epc_pkg::LAMBDA_LOW_RST;
            lambda_high_reg <= epc_pkg::LAMBDA_HIGH_RST;
            det_min_reg     <= epc_pkg::DET_MIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                epc_pkg::CFG_LAMBDA_LOW:  lambda_low_reg  <= cfg_data[epc_pkg::LAM_W-1:0];
                epc_pkg::CFG_LAMBDA_HIGH: lambda_high_reg <= cfg_data[epc_pkg::LAM_W-1:0];
                epc_pkg::CFG_DET_MIN:     det_min_reg     <= cfg_data[epc_pkg::DETMIN_W-1:0];
                default:                  ;
            endcase
        end
    end

    // Point count and segment walk index.
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] k_reg;
    logic [CNT_W-1:0] k_plus;
    logic             last_seg;
    logic [IDX_W-1:0] k1;
    logic             full;

    assign full     = count_reg >= CNT_W'(MAX_POINTS);
    assign k_plus   = CNT_W'(k_reg) + CNT_W'(1);
    assign last_seg = k_plus == count_reg;
    assign k1       = last_seg ? '0 : k_plus[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            k_reg     <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                count_reg <= '0;
            end
            else if (cmd.append && !full)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.seg_first)
            begin
                k_reg <= '0;
            end
            else if (cmd.seg_next)
            begin
                k_reg <= k_plus[IDX_W-1:0];
            end
        end
    end

    // Polyline point memory, one write and one registered read port.
    logic signed [epc_pkg::COORD_W-1:0] mem_x [MAX_POINTS];
    logic signed [epc_pkg::COORD_W-1:0] mem_y [MAX_POINTS];
    logic signed [epc_pkg::COORD_W-1:0] rd_x, rd_y;
    logic [IDX_W-1:0]                   rd_addr;

    assign rd_addr = cmd.rd_q ? k1 : k_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.append && !full)
        begin
            mem_x[count_reg[IDX_W-1:0]] <= ax;
            mem_y[count_reg[IDX_W-1:0]] <= ay;
        end
        rd_x <= mem_x[rd_addr];
        rd_y <= mem_y[rd_addr];
    end

    // Edge operands and segment differences.
    logic signed [epc_pkg::COORD_W-1:0] ax_reg, ay_reg, px_reg, py_reg;
    logic signed [DIFF_W-1:0]           a_reg, c_reg, b_reg, d_reg, e_reg, f_reg;
    logic                               swp_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_edge)
        begin
            ax_reg  <= ax;
            ay_reg  <= ay;
            a_reg   <= epc_pkg::sub_ext(bx, ax);
            c_reg   <= epc_pkg::sub_ext(by, ay);
            swp_reg <= swapped;
        end
        if (cmd.rd_q)
        begin
            px_reg <= rd_x;
            py_reg <= rd_y;
        end
        if (cmd.load)
        begin
            b_reg <= epc_pkg::sub_ext(px_reg, rd_x);
            d_reg <= epc_pkg::sub_ext(py_reg, rd_y);
            e_reg <= epc_pkg::sub_ext(px_reg, ax_reg);
            f_reg <= epc_pkg::sub_ext(py_reg, ay_reg);
        end
    end

    // Shared multiplier with a registered product.
    logic signed [DIFF_W-1:0] ma, mb;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  prod_ext;

    always_comb
    begin
        case (cmd.mul_sel)
            epc_pkg::MUL_AD: begin ma = a_reg; mb = d_reg; end
            epc_pkg::MUL_BC: begin ma = b_reg; mb = c_reg; end
            epc_pkg::MUL_DE: begin ma = d_reg; mb = e_reg; end
            epc_pkg::MUL_BF: begin ma = b_reg; mb = f_reg; end
            epc_pkg::MUL_AF: begin ma = a_reg; mb = f_reg; end
            epc_pkg::MUL_CE: begin ma = c_reg; mb = e_reg; end
            default:         begin ma = '0;    mb = '0;    end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(ma) * PROD_W'(mb);
    end

    assign prod_ext = {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    // Determinant and numerators, then sign normalization.
    logic signed [ACC_W-1:0] det_reg, n0_reg, n1_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.acc_en)
        begin
            case (cmd.acc_sel)
                epc_pkg::MUL_AD: det_reg <= prod_ext;
                epc_pkg::MUL_BC: det_reg <= det_reg - prod_ext;
                epc_pkg::MUL_DE: n0_reg  <= prod_ext;
                epc_pkg::MUL_BF: n0_reg  <= n0_reg - prod_ext;
                epc_pkg::MUL_AF: n1_reg  <= prod_ext;
                epc_pkg::MUL_CE: n1_reg  <= n1_reg - prod_ext;
                default:         ;
            endcase
        end
        else if (cmd.norm && det_reg[ACC_W-1])
        begin
            det_reg <= -det_reg;
            n0_reg  <= -n0_reg;
            n1_reg  <= -n1_reg;
        end
    end

    // Crossing qualification on the normalized values.
    logic seg_ok;

    assign seg_ok = (det_reg != '0)
                 && ($unsigned(det_reg) >= ACC_W'(det_min_reg))
                 && !n0_reg[ACC_W-1] && (n0_reg <= det_reg)
                 && !n1_reg[ACC_W-1] && (n1_reg <= det_reg);

    // Rounded lambda.
    logic                      div_done;
    logic [epc_pkg::LAM_W-1:0] quot;

    epc_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (n0_reg[ACC_W-2:0]),
        .den   (det_reg[ACC_W-2:0]),
        .done  (div_done),
        .quot  (quot)
    );

    // Status toward the controller.
    always_comb
    begin
        stat.is_append = req_type == epc_pkg::REQ_APPEND;
        stat.is_clear  = req_type == epc_pkg::REQ_CLEAR;
        stat.is_test   = req_type == epc_pkg::REQ_TEST;
        stat.full      = full;
        stat.few       = count_reg < CNT_W'(3);
        stat.depth_bad = (az <= epc_pkg::DEPTH_NEG) || (az >= epc_pkg::DEPTH_POS)
                      || (bz <= epc_pkg::DEPTH_NEG) || (bz >= epc_pkg::DEPTH_POS);
        stat.seg_ok    = seg_ok;
        stat.last_seg  = last_seg;
        stat.div_done  = div_done;
        stat.lam_ok    = (quot >= lambda_low_reg) && (quot <= lambda_high_reg);
    end

    // Result register, shown for one cycle.
    logic                         done_reg;
    logic [epc_pkg::STATUS_W-1:0] status_reg;
    logic                         hit_reg;
    logic [IDX_W-1:0]             seg_reg;
    logic [epc_pkg::LAM_W-1:0]    t_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status_reg <= cmd.res_status;
            hit_reg    <= cmd.res_hit;
            seg_reg    <= cmd.res_hit ? k_reg : '0;
            t_reg      <= !cmd.res_hit ? '0 : (swp_reg ? epc_pkg::Q16_ONE - quot : quot);
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign hit           = hit_reg;
    assign segment_index = seg_reg;
    assign split_t       = t_reg;
    assign point_total   = count_reg;

endmodule

`default_nettype wire

>>> design/epc_ctrl.sv
`default_nettype none

module epc_ctrl
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire epc_pkg::epc_stat_t  stat,
    output epc_pkg::epc_cmd_t        cmd,
    output logic                     busy
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RD_P  = 9'b000000010,
        S_RD_Q  = 9'b000000100,
        S_LOAD  = 9'b000001000,
        S_MULT  = 9'b000010000,
        S_NORM  = 9'b000100000,
        S_CHECK = 9'b001000000,
        S_DIV   = 9'b010000000,
        S_ADV   = 9'b100000000
    } state_t;

    state_t                    state_reg, state_next;
    logic [epc_pkg::SEL_W-1:0] step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.emit = 1'b1;
                    if (stat.is_append)
                    begin
                        cmd.append     = 1'b1;
                        cmd.res_status = stat.full ? epc_pkg::ST_FULL : epc_pkg::ST_DONE;
                    end
                    else if (stat.is_clear)
                    begin
                        cmd.clear = 1'b1;
                    end
                    else if (stat.is_test)
                    begin
                        if (stat.few)
                        begin
                            cmd.res_status = epc_pkg::ST_FEW;
                        end
                        else if (stat.depth_bad)
                        begin
                            cmd.res_status = epc_pkg::ST_DEPTH;
                        end
                        else
                        begin
                            cmd.emit       = 1'b0;
                            cmd.latch_edge = 1'b1;
                            cmd.seg_first  = 1'b1;
                            state_next     = S_RD_P;
                        end
                    end
                end
            end
            S_RD_P:
            begin
                state_next = S_RD_Q;
            end
            S_RD_Q:
            begin
                cmd.rd_q   = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                step_next  = '0;
                state_next = S_MULT;
            end
            S_MULT:
            begin
                // Issue one product and accumulate the previous one each cycle.
                cmd.mul_sel = step_reg;
                cmd.acc_en  = step_reg != '0;
                cmd.acc_sel = step_reg - 1'b1;
                step_next   = step_reg + 1'b1;
                if (step_reg == epc_pkg::MUL_LAST)
                begin
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                cmd.norm   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.seg_ok)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    state_next = S_ADV;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    if (stat.lam_ok)
                    begin
                        cmd.emit    = 1'b1;
                        cmd.res_hit = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_ADV;
                    end
                end
            end
            S_ADV:
            begin
                if (stat.last_seg)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.seg_next = 1'b1;
                    state_next   = S_RD_P;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign busy = state_reg != S_IDLE;

    // A result from the walk always returns the controller to idle.
    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && state_reg != S_IDLE) |=> state_reg == S_IDLE)
        else $error("walk result did not return to idle");

    // The divider starts only on a qualified crossing.
    a_div_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> (state_reg == S_CHECK && stat.seg_ok))
        else $error("division started without a qualified crossing");

    // Division completion leaves the wait state.
    a_div_leave: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && stat.div_done) |=> state_reg != S_DIV)
        else $error("division done but still waiting");

    // The product step counter never runs past the last accumulate.
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MULT |-> step_reg <= epc_pkg::MUL_LAST)
        else $error("product step out of range");

endmodule

`default_nettype wire

>>> design/edge_polyline_crossing_unit.sv
`default_nettype none

// Edge versus closed polyline crossing unit.
// Command channel: an item is taken at a clock edge with start high and busy
// low. req_type selects append point (ax, ay), clear polyline, or edge test of
// A(ax, ay, az) to B(bx, by, bz). Each item gives one result beat: done is high
// for one cycle with status, hit, segment_index, split_t and point_total.
// Append, clear, an unused code, and an edge test rejected for too few points
// or depth range give their beat in the cycle after the item; busy stays low,
// so a new item may be taken every cycle.
// An edge test that walks the polyline steps through each segment tested
// (two memory reads, difference load, six products through one shared
// 21x21 multiplier, then emptying it, sign normalization, check,
// advance). Each qualified crossing adds a pass through the restoring divider,
// and the walk stops at the first crossing within the margins.
// busy is high during the walk.
// The receiver cannot stall: each beat is shown for exactly one cycle.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// the user must make them while the block is idle, which it does not enforce.
// Reset clears the point count and restores default margins, not point memory.
module edge_polyline_crossing_unit
#(
    parameter int MAX_POINTS = epc_pkg::DEFAULT_MAX_POINTS,
    parameter int IDX_W      = $clog2(MAX_POINTS),
    parameter int CNT_W      = $clog2(MAX_POINTS + 1)
)
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [epc_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [epc_pkg::CFG_W-1:0]              cfg_data,
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic [epc_pkg::REQ_W-1:0]              req_type,
    input  wire logic signed [epc_pkg::COORD_W-1:0]     ax,
    input  wire logic signed [epc_pkg::COORD_W-1:0]     ay,
    input  wire logic signed [epc_pkg::COORD_W-1:0]     bx,
    input  wire logic signed [epc_pkg::COORD_W-1:0]     by,
    input  wire logic signed [epc_pkg::DEPTH_W-1:0]     az,
    input  wire logic signed [epc_pkg::DEPTH_W-1:0]     bz,
    input  wire logic                                   swapped,
    output logic                                        done,
    output logic [epc_pkg::STATUS_W-1:0]                status,
    output logic                                        hit,
    output logic [IDX_W-1:0]                            segment_index,
    output logic [epc_pkg::LAM_W-1:0]                   split_t,
    output logic [CNT_W-1:0]                            point_total
);

    epc_pkg::epc_cmd_t  cmd;
    epc_pkg::epc_stat_t stat;

    epc_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    epc_datapath
    #(
        .MAX_POINTS (MAX_POINTS),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .req_type      (req_type),
        .ax            (ax),
        .ay            (ay),
        .bx            (bx),
        .by            (by),
        .az            (az),
        .bz            (bz),
        .swapped       (swapped),
        .done          (done),
        .status        (status),
        .hit           (hit),
        .segment_index (segment_index),
        .split_t       (split_t),
        .point_total   (point_total)
    );

endmodule

`default_nettype wire

>>> bench/edge_polyline_crossing_unit_tb.sv
`default_nettype none

module edge_polyline_crossing_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS      = epc_pkg::DEFAULT_MAX_POINTS;
    localparam int STALL_MAX = 10000;

    typedef struct {
        logic [epc_pkg::REQ_W-1:0]          req;
        logic signed [epc_pkg::COORD_W-1:0] ax, ay, bx, by;
        logic signed [epc_pkg::DEPTH_W-1:0] az, bz;
        logic                               swp;
    } edge_req_t;

    typedef struct {
        logic [epc_pkg::STATUS_W-1:0] status;
        logic                         hit;
        logic [5:0]                   seg;
        logic [epc_pkg::LAM_W-1:0]    t;
        logic [6:0]                   total;
    } crossing_t;

    // Scoreboard: keeps a private copy of the polyline and margins and
    // queues the crossing answer for every accepted beat.
    class crossing_scoreboard;
        bit [epc_pkg::LAM_W-1:0]    lam_lo = epc_pkg::LAMBDA_LOW_RST;
        bit [epc_pkg::LAM_W-1:0]    lam_hi = epc_pkg::LAMBDA_HIGH_RST;
        bit [epc_pkg::DETMIN_W-1:0] det_floor = epc_pkg::DET_MIN_RST;
        longint                     px[NPTS];
        longint                     py[NPTS];
        int                         count = 0;
        crossing_t                  crossing_q[$];

        function void note_item(edge_req_t it);
            crossing_t r;
            longint a, c, b, d, e, f, det, n0, n1, lam;
            int k1;
            r = '{epc_pkg::ST_DONE, 1'b0, 6'd0, '0, 7'd0};
            if (it.req == epc_pkg::REQ_APPEND) begin
                if (count >= NPTS) r.status = epc_pkg::ST_FULL;
                else begin
                    px[count] = longint'(it.ax);
                    py[count] = longint'(it.ay);
                    count++;
                end
            end else if (it.req == epc_pkg::REQ_CLEAR) begin
                count = 0;
            end else if (it.req == epc_pkg::REQ_TEST) begin
                if (count < 3) r.status = epc_pkg::ST_FEW;
                else if (it.az <= epc_pkg::DEPTH_NEG || it.az >= epc_pkg::DEPTH_POS ||
                         it.bz <= epc_pkg::DEPTH_NEG || it.bz >= epc_pkg::DEPTH_POS)
                    r.status = epc_pkg::ST_DEPTH;
                else begin
                    a = longint'(it.bx) - longint'(it.ax);
                    c = longint'(it.by) - longint'(it.ay);
                    // Walk segments in order; the first qualifying one wins.
                    for (int k = 0; k < count; k++) begin
                        k1 = (k + 1 == count) ? 0 : k + 1;
                        b = px[k] - px[k1];
                        d = py[k] - py[k1];
                        e = px[k] - longint'(it.ax);
                        f = py[k] - longint'(it.ay);
                        det = a * d - b * c;
                        n0 = d * e - b * f;
                        n1 = a * f - c * e;
                        if (det == 0) continue;
                        if ((det < 0 ? -det : det) < longint'(det_floor)) continue;
                        if (det < 0) begin
                            det = -det;
                            n0 = -n0;
                            n1 = -n1;
                        end
                        if (n0 < 0 || n0 > det || n1 < 0 || n1 > det) continue;
                        lam = (n0 * 65536 + det / 2) / det;
                        if (lam < longint'(lam_lo) || lam > longint'(lam_hi)) continue;
                        r.hit = 1'b1;
                        r.seg = 6'(k);
                        r.t = it.swp ? epc_pkg::LAM_W'(65536 - lam) : epc_pkg::LAM_W'(lam);
                        break;
                    end
                end
            end
            r.total = 7'(count);
            crossing_q = {crossing_q, r};
        endfunction

        // Returns an empty string when the beat matches the oldest answer.
        function string check(crossing_t got);
            crossing_t w;
            string msg;
            if (crossing_q.size() == 0) return "result beat with nothing pending";
            w = crossing_q.pop_front();
            msg = "";
            if (got.status !== w.status)
                msg = {msg, $sformatf(" status %0d/%0d", got.status, w.status)};
            if (got.hit !== w.hit)
                msg = {msg, $sformatf(" hit %0d/%0d", got.hit, w.hit)};
            if (got.seg !== w.seg)
                msg = {msg, $sformatf(" segment %0d/%0d", got.seg, w.seg)};
            if (got.t !== w.t)
                msg = {msg, $sformatf(" split_t %0d/%0d", got.t, w.t)};
            if (got.total !== w.total)
                msg = {msg, $sformatf(" points %0d/%0d", got.total, w.total)};
            return msg;
        endfunction
    endclass

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_we = 1'b0;
    logic [epc_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
    logic [epc_pkg::CFG_W-1:0]           cfg_data = '0;
    logic                                start = 1'b0;
    logic                                busy;
    logic [epc_pkg::REQ_W-1:0]           req_type = '0;
    logic signed [epc_pkg::COORD_W-1:0]  ax = '0, ay = '0, bx = '0, by = '0;
    logic signed [epc_pkg::DEPTH_W-1:0]  az = '0, bz = '0;
    logic                                swapped = 1'b0;
    logic                                done;
    logic [epc_pkg::STATUS_W-1:0]        status;
    logic                                hit;
    logic [5:0]                          segment_index;
    logic [epc_pkg::LAM_W-1:0]           split_t;
    logic [6:0]                          point_total;

    crossing_scoreboard sb = new();
    int errors = 0;
    int stall_cnt = 0;
    int idle_pct = 0;

    edge_polyline_crossing_unit dut (.*);

    always #10 clk = ~clk;

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t:%s", $realtime, msg);
        errors++;
    endtask

    // Result monitor: the receiver takes every beat in its one cycle.
    always @(posedge clk) begin
        string m;
        if (rst_n && done) begin
            m = sb.check('{status, hit, segment_index, split_t, point_total});
            if (m != "") report_mismatch(m);
        end
    end

    // Watchdog on cycles with no beat moving either way.
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done) stall_cnt <= 0;
        else stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_MAX) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(logic [epc_pkg::CFG_IDX_W-1:0] idx,
                             logic [epc_pkg::CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == epc_pkg::CFG_LAMBDA_LOW) sb.lam_lo = val[epc_pkg::LAM_W-1:0];
        else if (idx == epc_pkg::CFG_LAMBDA_HIGH) sb.lam_hi = val[epc_pkg::LAM_W-1:0];
        else sb.det_floor = val[epc_pkg::DETMIN_W-1:0];
    endtask

    // Present one beat and hold it until the block takes it.
    task automatic send_item(edge_req_t it);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req_type <= it.req;
        ax <= it.ax;
        ay <= it.ay;
        bx <= it.bx;
        by <= it.by;
        az <= it.az;
        bz <= it.bz;
        swapped <= it.swp;
        start <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_item(it);
    endtask

    // Drop start and wait until every answer has come back.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.crossing_q.size() != 0) @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    function automatic logic signed [epc_pkg::COORD_W-1:0] rand_coord(int span);
        if (span == 0) return epc_pkg::COORD_W'($urandom);
        return epc_pkg::COORD_W'($urandom_range(0, 2 * span) - span);
    endfunction

    function automatic logic signed [epc_pkg::DEPTH_W-1:0] rand_depth();
        if ($urandom_range(0, 9) == 0) return epc_pkg::DEPTH_W'($urandom);
        return epc_pkg::DEPTH_W'($urandom_range(0, 32766) - 16383);
    endfunction

    function automatic edge_req_t make_item(logic [epc_pkg::REQ_W-1:0] rq, int span);
        edge_req_t it;
        it.req = rq;
        it.ax = rand_coord(span);
        it.ay = rand_coord(span);
        it.bx = rand_coord(span);
        it.by = rand_coord(span);
        it.az = rand_depth();
        it.bz = rand_depth();
        it.swp = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Clear and lay down a fresh polyline, mostly short ones.
    task automatic build_poly(int span, ref int sent);
        int n;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 66) : $urandom_range(3, 10);
        send_item(make_item(epc_pkg::REQ_CLEAR, span));
        sent++;
        repeat (n) begin
            send_item(make_item(epc_pkg::REQ_APPEND, span));
            sent++;
        end
    endtask

    function automatic logic [epc_pkg::REQ_W-1:0] REQ_TYPE_NOISE(int pick);
        if (pick < 93) return epc_pkg::REQ_APPEND;
        if (pick < 97) return epc_pkg::REQ_UNUSED;
        return epc_pkg::REQ_CLEAR;
    endfunction

    task automatic random_phase(int n_items);
        int sent;
        int span;
        int pick;
        sent = 0;
        span = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (sb.count < 3 || pick < 8) begin
                span = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(16, 4096);
                build_poly(span, sent);
            end else if (pick < 88) begin
                send_item(make_item(epc_pkg::REQ_TEST, span));
                sent++;
            end else begin
                // Noise: unused code, stray append, or a clear.
                send_item(make_item(REQ_TYPE_NOISE(pick), 0));
                sent++;
            end
        end
    endtask

    task automatic directed();
        edge_req_t it;
        it = '{epc_pkg::REQ_TEST, 20'sd0, 20'sd0, 20'sd100, 20'sd100, 16'sd0, 16'sd0, 1'b0};
        send_item(it);                              // too few points
        it.req = epc_pkg::REQ_UNUSED;
        send_item(it);                              // unused request code
        it.req = epc_pkg::REQ_CLEAR;
        send_item(it);
        // Square at the coordinate extremes.
        it.req = epc_pkg::REQ_APPEND;
        it.ax = -20'sd524288; it.ay = -20'sd524288; send_item(it);
        it.ax = 20'sd524287;  send_item(it);
        it.ay = 20'sd524287;  send_item(it);
        it.ax = -20'sd524288; send_item(it);
        // Edge tests: diagonal, swapped order, depth limits.
        it = '{epc_pkg::REQ_TEST, -20'sd1000, 20'sd0, 20'sd524287, 20'sd3000,
               16'sd16383, -16'sd16383, 1'b0};
        send_item(it);
        it.swp = 1'b1;
        send_item(it);
        it.az = epc_pkg::DEPTH_NEG;     send_item(it);
        it.az = 16'sd0; it.bz = epc_pkg::DEPTH_POS; send_item(it);
        it.bz = 16'sh7FFF;     send_item(it);
        it.bz = 16'sh8000;     send_item(it);
        // Side-parallel edges (zero determinant) and a diagonal, no floor.
        drain();
        write_reg(epc_pkg::CFG_DET_MIN, '0);
        it = '{epc_pkg::REQ_TEST, -20'sd524288, 20'sd5, 20'sd524287, 20'sd5,
               16'sd0, 16'sd0, 1'b0};
        send_item(it);
        it = '{epc_pkg::REQ_TEST, 20'sd0, -20'sd524288, 20'sd0, 20'sd524287,
               16'sd0, 16'sd0, 1'b1};
        send_item(it);
        it = '{epc_pkg::REQ_TEST, -20'sd524288, 20'sd524287, 20'sd524287, -20'sd524288,
               16'sd0, 16'sd0, 1'b0};
        send_item(it);
        drain();
    endtask

    initial begin
        int pct[4];
        logic [epc_pkg::CFG_W-1:0] lo, hi, dm;
        pct = '{0, 45, 0, 15};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed();
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin
                    lo = epc_pkg::CFG_W'(328);
                    hi = epc_pkg::CFG_W'(65208);
                    dm = epc_pkg::CFG_W'(1);
                end
                1: begin
                    lo = '0;
                    hi = epc_pkg::CFG_W'(65536);
                    dm = '0;
                end
                2: begin
                    lo = epc_pkg::CFG_W'(65536);
                    hi = '0;
                    dm = epc_pkg::CFG_W'(1);
                end
                3: begin
                    lo = '0;
                    hi = epc_pkg::CFG_W'(65536);
                    dm = epc_pkg::CFG_W'(1) << 40;
                end
                default: begin
                    lo = epc_pkg::CFG_W'($urandom_range(0, 30000));
                    hi = epc_pkg::CFG_W'($urandom_range(35000, 65536));
                    dm = (epc_pkg::CFG_W'(1) << $urandom_range(0, 38))
                       | epc_pkg::CFG_W'($urandom_range(0, 255));
                end
            endcase
            write_reg(epc_pkg::CFG_LAMBDA_LOW, lo);
            write_reg(epc_pkg::CFG_LAMBDA_HIGH, hi);
            write_reg(epc_pkg::CFG_DET_MIN, dm);
            idle_pct = pct[p % 4];
            random_phase(80);
            // Hold the sender back until every answer has arrived.
            start <= 1'b0;
            @(posedge clk);
            while (sb.crossing_q.size() != 0) @(posedge clk);
            random_phase(80);
            drain();
        end
        repeat (50) @(posedge clk);
        if (errors == 0 && sb.crossing_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
design/epc_pkg.sv
design/epc_div.sv
design/epc_datapath.sv
design/epc_ctrl.sv
design/edge_polyline_crossing_unit.sv
bench/edge_polyline_crossing_unit_tb.sv
